[design/lfsf_pkg.sv]
// ----------------------------------------------------------------------------
// lfsf_pkg
// Shared widths, constants and payload types for the largest free square
// finder.
// ----------------------------------------------------------------------------
package lfsf_pkg;

  // Field widths
  localparam int SIZE_W    = 11;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;
  localparam int CFG_W     = 11;

  // Largest side a size register can hold; larger sides saturate here
  localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

  // Row width after reset
  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd1024;

  // One map cell
  typedef struct packed {
    logic is_obstacle;
    logic last_cell;
  } cell_t;

  // One result, sent on the map's last cell
  typedef struct packed {
    logic [SIZE_W-1:0]    square_size;
    logic [ROW_W-1:0]     bottom_row;
    logic [OUT_COL_W-1:0] right_col;
  } result_t;

endpackage

[design/lfsf_ram.sv]
// ----------------------------------------------------------------------------
// lfsf_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module lfsf_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/largest_free_square_finder_core.sv]
// ----------------------------------------------------------------------------
// largest_free_square_finder_core
// Streams map cells in raster order and reports the largest all-free square.
// ----------------------------------------------------------------------------
// Usage:
//   cell channel (cell_valid/cell_ready/map_cell): one request per map cell,
//   in raster order; map_cell.last_cell marks the final cell of a map.
//   result channel (result_valid/result_ready/result): one result per map,
//   carrying the side of the largest free square and the row and column of
//   the first bottom-right corner that reaches it (all zero if none).
//   cfg_we/cfg_wdata write the row width; write only while the block is idle.
// Throughput: one cell per cycle, outside the clearing pass and result stalls.
//   The line buffer RAM is read when a cell is taken and written when it leaves
//   the second stage, with a forwarding path for width one.
// Result: registered as the last cell leaves the second stage. Reset: rst clears
//   all control state and sets the row width to 1024, then a clearing pass
//   zeroes the line buffer, one entry per cycle, with cell_ready held low.
// Stalls: a held result does not stop ordinary cells; only a further last
//   cell waits in the second stage until the pending result is taken.
// ----------------------------------------------------------------------------
module largest_free_square_finder_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cell_valid,
  output logic                     cell_ready,
  input  lfsf_pkg::cell_t          map_cell,
  output logic                     result_valid,
  input  logic                     result_ready,
  output lfsf_pkg::result_t        result,
  input  logic                     cfg_we,
  input  logic [lfsf_pkg::CFG_W-1:0] cfg_wdata
);

  import lfsf_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW    = COL_W + 1;

  // Configuration and map position
  logic [CFG_W-1:0]  row_width;
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic              first_row;

  // Line buffer clearing pass
  logic              clearing;
  logic [COL_W-1:0]  clr_addr;

  // Second stage
  logic              s1_valid;
  logic              s1_obst;
  logic              s1_last;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic              s1_first;
  logic              s1_hit;
  logic [SIZE_W-1:0] s1_fwd;

  // Neighbor and best-so-far state
  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diag_size;
  logic [SIZE_W-1:0] best_size;
  logic [ROW_W-1:0]  best_row;
  logic [COL_W-1:0]  best_col;

  // Combinational signals
  logic [CW-1:0]     width_eff;
  logic [COL_W-1:0]  col_sel;
  logic [CW-1:0]     col_plus;
  logic              accept;
  logic              s1_go;
  logic              s1_fire;
  logic [SIZE_W-1:0] ram_rdata;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [SIZE_W-1:0] ram_wdata;
  logic [SIZE_W-1:0] up_val;
  logic [SIZE_W-1:0] left_val;
  logic [SIZE_W-1:0] diag_val;
  logic [SIZE_W-1:0] min_lu;
  logic [SIZE_W-1:0] min_all;
  logic [SIZE_W-1:0] size;
  logic              better;

  // Effective row width: zero reads as one, clamp to the buffer depth
  always_comb begin
    if (row_width == '0) begin
      width_eff = CW'(1);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(row_width);
    end
  end

  // Column of the incoming cell, wrapped if the width shrank
  assign col_sel  = ({1'b0, col_count} >= width_eff) ? '0 : col_count;
  assign col_plus = {1'b0, col_sel} + CW'(1);

  // Handshake
  assign s1_go      = !s1_last || !result_valid || result_ready;
  assign s1_fire    = s1_valid && s1_go;
  assign cell_ready = !clearing && (!s1_valid || s1_go);
  assign accept     = cell_valid && cell_ready;

  // Line buffer write port: clearing pass or second stage
  assign ram_we    = clearing || s1_fire;
  assign ram_waddr = clearing ? clr_addr : s1_col;
  assign ram_wdata = clearing ? '0 : size;

  lfsf_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_sel),
    .rdata (ram_rdata)
  );

  // Square size of the cell in the second stage
  always_comb begin
    up_val   = s1_first ? '0 : (s1_hit ? s1_fwd : ram_rdata);
    left_val = (s1_col == '0) ? '0 : left_size;
    diag_val = (s1_col == '0 || s1_first) ? '0 : diag_size;
    min_lu   = (left_val < up_val) ? left_val : up_val;
    min_all  = (min_lu < diag_val) ? min_lu : diag_val;
    if (s1_obst) begin
      size = '0;
    end else if (min_all == SIZE_SAT) begin
      size = SIZE_SAT;
    end else begin
      size = min_all + SIZE_W'(1);
    end
    better = size > best_size;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Map position, advanced when a cell is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      first_row <= 1'b1;
    end else if (accept) begin
      if (map_cell.last_cell) begin
        col_count <= '0;
        row_count <= '0;
        first_row <= 1'b1;
      end else if (col_plus >= width_eff) begin
        col_count <= '0;
        row_count <= row_count + ROW_W'(1);
        first_row <= 1'b0;
      end else begin
        col_count <= col_plus[COL_W-1:0];
      end
    end
  end

  // Second stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_hit   <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_hit   <= s1_fire && (s1_col == col_sel);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
      s1_hit   <= 1'b0;
    end
  end

  // Second stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_obst  <= map_cell.is_obstacle;
      s1_last  <= map_cell.last_cell;
      s1_col   <= col_sel;
      s1_row   <= row_count;
      s1_first <= first_row;
      s1_fwd   <= size;
    end
  end

  // Neighbor and best tracking; restart after the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      best_size <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        left_size <= '0;
        diag_size <= '0;
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        left_size <= size;
        diag_size <= up_val;
        if (better) begin
          best_size <= size;
          best_row  <= s1_row;
          best_col  <= s1_col;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      if (better) begin
        result.square_size <= size;
        result.bottom_row  <= s1_row;
        result.right_col   <= OUT_COL_W'(s1_col);
      end else begin
        result.square_size <= best_size;
        result.bottom_row  <= best_row;
        result.right_col   <= OUT_COL_W'(best_col);
      end
    end
  end

`ifndef SYNTH
  // No cell is taken while the line buffer is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cell_ready)
    else $error("cell taken during line buffer clear");

  // A last cell held behind a pending result must not touch the buffer
  a_stall_no_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && result_valid && !result_ready) |-> !ram_we)
    else $error("line buffer written by a stalled cell");

  // Forwarding flag only exists alongside a cell in the second stage
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    s1_hit |-> s1_valid)
    else $error("forwarding flag without a cell");

  // A new result only follows a last cell leaving the second stage
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && s1_last && s1_go))
    else $error("result without a last cell");
`endif

endmodule

[tb/largest_free_square_finder_core_tb.sv]
// ----------------------------------------------------------------------------
// largest_free_square_finder_core_tb
// Streams binary maps through the square finder and checks each reported
// square against a cycle-free model of the line-buffer recurrence. Covers
// hand-built corner maps, randomized maps over many row widths (including
// width changes mid-map), the clamped maximum width and a lone free cell at
// width one, with random gaps on the cell side and random result stalls.
// ----------------------------------------------------------------------------
module largest_free_square_finder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfsf_pkg::*;

  localparam int LINE_DEPTH   = 1024;  // matches the core's MAX_WIDTH
  localparam int IDLE_PCT     = 23;
  localparam int RAND_CELLS   = 380;
  localparam int SETTLE_CYCLES = 8;

  // Square model plus queue of pending reports
  class square_scoreboard;
    logic [CFG_W-1:0]     row_width;
    logic [SIZE_W-1:0]    line_sizes [LINE_DEPTH];
    logic [SIZE_W-1:0]    left_sz, diag_sz, best_sz;
    logic [OUT_COL_W-1:0] col_cnt, best_col;
    logic [ROW_W-1:0]     row_cnt, best_row;
    bit                   top_row;
    result_t              pending_squares[$];
    int                   errors;

    function new();
      foreach (line_sizes[i]) line_sizes[i] = '0;
      row_width = ROW_WIDTH_RESET;
      errors    = 0;
      start_map();
    endfunction

    function void start_map();
      left_sz  = '0;
      diag_sz  = '0;
      col_cnt  = '0;
      row_cnt  = '0;
      best_sz  = '0;
      best_row = '0;
      best_col = '0;
      top_row  = 1'b1;
    endfunction

    // Advance the model by one accepted cell request
    function void note_cell(cell_t c);
      int      w, col, up, left, diag, sz;
      result_t r;
      w = row_width;
      if (w == 0) w = 1;
      else if (w > LINE_DEPTH) w = LINE_DEPTH;
      col = col_cnt;
      if (col >= w) col = 0;

      // neighbors; row 0 ignores whatever the line buffer holds
      up   = top_row ? 0 : line_sizes[col];
      left = (col == 0) ? 0 : left_sz;
      diag = (col == 0 || top_row) ? 0 : diag_sz;

      if (c.is_obstacle) begin
        sz = 0;
      end else begin
        sz = (left < up) ? left : up;
        if (diag < sz) sz = diag;
        sz = sz + 1;
        if (sz > SIZE_SAT) sz = SIZE_SAT;
      end

      // strictly greater only: first corner in raster order wins ties
      if (sz > best_sz) begin
        best_sz  = SIZE_W'(sz);
        best_row = row_cnt;
        best_col = OUT_COL_W'(col);
      end

      line_sizes[col] = SIZE_W'(sz);
      left_sz         = SIZE_W'(sz);
      diag_sz         = SIZE_W'(up);

      if (c.last_cell) begin
        r.square_size = best_sz;
        r.bottom_row  = best_row;
        r.right_col   = best_col;
        pending_squares.push_back(r);
        start_map();
      end else if (col + 1 >= w) begin
        col_cnt = '0;
        row_cnt = row_cnt + 1'b1;
        top_row = 1'b0;
      end else begin
        col_cnt = OUT_COL_W'(col + 1);
      end
    endfunction

    // Compare one accepted result with the oldest pending report
    function void check_result(result_t got);
      result_t want;
      if (pending_squares.size() == 0) begin
        $display("%0t: unexpected result: size %0d row %0d col %0d", $time,
                 got.square_size, got.bottom_row, got.right_col);
        errors++;
        return;
      end
      want = pending_squares.pop_front();
      if (got.square_size !== want.square_size) begin
        $display("%0t: square_size mismatch: expected %0d, actual %0d", $time,
                 want.square_size, got.square_size);
        errors++;
      end
      if (got.bottom_row !== want.bottom_row) begin
        $display("%0t: bottom_row mismatch: expected %0d, actual %0d", $time,
                 want.bottom_row, got.bottom_row);
        errors++;
      end
      if (got.right_col !== want.right_col) begin
        $display("%0t: right_col mismatch: expected %0d, actual %0d", $time,
                 want.right_col, got.right_col);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cell_valid = 1'b0;
  logic             cell_ready;
  cell_t            cell_in = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  result_t          result_out;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  bit               quiet = 1'b0;  // no gaps and no stalls while set

  square_scoreboard sb = new();

  // Ports in order: clk, rst, cell valid/ready/payload, result
  // valid/ready/payload, cfg_we, cfg_wdata
  largest_free_square_finder_core DUT (
    clk, rst,
    cell_valid, cell_ready, cell_in,
    result_valid, result_ready, result_out,
    cfg_we, cfg_wdata
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Accepted requests on both channels
  always @(posedge clk) begin
    if (!rst && cell_valid && cell_ready) sb.note_cell(cell_in);
    if (!rst && result_valid && result_ready) sb.check_result(result_out);
  end

  // Result side back-pressure
  always @(negedge clk) begin
    result_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Hard stop
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // One cell request; called and returns at a falling edge
  task automatic send_cell(input cell_t c);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      cell_valid <= 1'b0;
      @(negedge clk);
    end
    cell_valid <= 1'b1;
    cell_in    <= c;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random cells at a given obstacle density
  task automatic send_map(input int unsigned len, input int unsigned pct,
                          input bit with_last);
    cell_t c;
    for (int unsigned i = 0; i < len; i++) begin
      c.is_obstacle = ($urandom_range(99) < pct);
      c.last_cell   = with_last && (i == len - 1);
      send_cell(c);
    end
  endtask

  // All obstacles except one free cell; always closed by a last cell
  task automatic send_lone_free(input int unsigned len, input int unsigned free_idx);
    cell_t c;
    for (int unsigned i = 0; i < len; i++) begin
      c.is_obstacle = (i != free_idx);
      c.last_cell   = (i == len - 1);
      send_cell(c);
    end
  endtask

  // Let the core drain, then write the row width
  task automatic drain_and_write(input logic [CFG_W-1:0] w);
    cell_valid <= 1'b0;
    while (sb.pending_squares.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    sb.row_width = w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned sent, w, ew, rows, len, pct, nmaps, phase;
    cell_t       c;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed maps at reset width: no free cell, lone free cell, tie in row
    send_cell('{is_obstacle: 1'b1, last_cell: 1'b1});
    send_cell('{is_obstacle: 1'b0, last_cell: 1'b1});
    send_cell('{is_obstacle: 1'b1, last_cell: 1'b0});
    send_cell('{is_obstacle: 1'b0, last_cell: 1'b0});
    send_cell('{is_obstacle: 1'b0, last_cell: 1'b0});
    send_cell('{is_obstacle: 1'b1, last_cell: 1'b1});

    // Width 3: full 3x3, then a map whose first row must not see the last one
    drain_and_write(11'd3);
    send_map(9, 0, 1'b1);
    send_map(3, 0, 1'b0);
    send_cell('{is_obstacle: 1'b1, last_cell: 1'b0});
    send_cell('{is_obstacle: 1'b0, last_cell: 1'b0});
    send_cell('{is_obstacle: 1'b0, last_cell: 1'b1});

    // Width zero behaves as one
    drain_and_write(11'd0);
    send_map(2, 0, 1'b1);

    // Random phases, mostly whole maps, some cut short or left open
    sent  = 0;
    phase = 0;
    while (sent < RAND_CELLS) begin
      case ($urandom_range(9))
        0:       w = 0;
        1:       w = 1;
        2:       w = 2;
        3:       w = $urandom_range(3, 8);
        8:       w = $urandom_range(17, 40);
        default: w = $urandom_range(2, 16);
      endcase
      drain_and_write(w[CFG_W-1:0]);
      if (phase == 1) quiet = 1'b1;
      if (phase == 3) quiet = 1'b0;
      ew    = (w == 0) ? 1 : w;
      nmaps = $urandom_range(1, 4);
      for (int unsigned m = 0; m < nmaps; m++) begin
        rows = (ew > 16) ? $urandom_range(1, 3) : $urandom_range(1, 6);
        case ($urandom_range(4))
          0:       pct = 0;
          1:       pct = 10;
          2:       pct = 30;
          3:       pct = 60;
          default: pct = $urandom_range(100);
        endcase
        if ($urandom_range(99) < 85) len = rows * ew;
        else len = $urandom_range(1, rows * ew + ew);
        send_map(len, pct, 1'b1);
        sent += len;
      end
      // open map carried across the next width change
      if ($urandom_range(99) < 30) begin
        len = $urandom_range(1, 2 * ew);
        send_map(len, 20, 1'b0);
        sent += len;
      end
      phase++;
    end
    quiet = 1'b0;

    // Width above the line depth clamps; corner lands in the last column
    drain_and_write(11'd2047);
    for (int unsigned i = 0; i < 1100; i++) begin
      c.is_obstacle = (i < 1023);
      c.last_cell   = (i == 1099);
      send_cell(c);
    end

    // Width one: lone free cell deep in the column
    drain_and_write(11'd1);
    send_lone_free(12, 7);

    // Wait for the last reports
    cell_valid <= 1'b0;
    while (sb.pending_squares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_squares.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
